FILE: rtl/framed_command_parser_failsafe_macros.svh
// assertion macros for the framed command parser and its checker
// depends on nothing; included by the checker file by its bare name
`ifndef FRAMED_COMMAND_PARSER_FAILSAFE_MACROS_SVH
`define FRAMED_COMMAND_PARSER_FAILSAFE_MACROS_SVH

// same-cycle implication, held off while reset is low
`define FCP_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, held off while reset is low
`define FCP_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/fcp_pkg.sv
// types and constants shared by the framed command parser
// depends on nothing
`default_nettype none

package fcp_pkg;

  // frame phases, one-hot
  typedef enum logic [4:0] {
    PH_IDLE = 5'b00001,
    PH_JOY  = 5'b00010,
    PH_BTN  = 5'b00100,
    PH_CHK  = 5'b01000,
    PH_TERM = 5'b10000
  } phase_t;

  typedef logic [1:0] event_t;
  localparam event_t EV_DRIVE    = 2'd0;
  localparam event_t EV_MISMATCH = 2'd1;
  localparam event_t EV_LOST     = 2'd2;

  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  localparam logic [7:0]  START_BYTE    = 8'h53;
  localparam logic [7:0]  STOP_JOY      = 8'h35;
  localparam logic [7:0]  BTN_RESET     = 8'h30;
  localparam logic [7:0]  CR_BYTE       = 8'h0D;
  localparam logic [7:0]  LF_BYTE       = 8'h0A;
  localparam logic [15:0] TIMEOUT_RESET = 16'd500;
  localparam logic [15:0] WDOG_MAX      = 16'hFFFF;

  typedef struct packed {
    phase_t      phase;
    logic [7:0]  joy;
    logic [7:0]  btn;
    logic [7:0]  chk;
    logic [15:0] wdog;
  } state_t;

  typedef struct packed {
    logic       valid;
    event_t     event_res;
    logic [7:0] joystick_code;
    logic [7:0] button_code;
  } result_t;

endpackage

`default_nettype wire

FILE: rtl/fcp_if.sv
// valid/ready channel interfaces for items in and results out
// depends on nothing
`default_nettype none

interface fcp_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] rx_byte;

  modport source (output valid, output kind, output rx_byte, input ready);
  modport sink   (input valid, input kind, input rx_byte, output ready);
endinterface

interface fcp_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] event_res;
  logic [7:0] joystick_code;
  logic [7:0] button_code;

  modport source (output valid, output event_res, output joystick_code,
                  output button_code, input ready);
  modport sink   (input valid, input event_res, input joystick_code,
                  input button_code, output ready);
endinterface

`default_nettype wire

FILE: rtl/framed_command_parser_failsafe.sv
// Framed command parser with link watchdog. Each input item is either a
// received serial byte (kind 0) or one timer tick (kind 1). Bytes are parsed
// as frames 'S', joystick, button, checksum, then CR or LF; at the terminator
// the xor of 'S', joystick and button is checked against the checksum and a
// drive command (event 0) or a mismatch report (event 1) is issued. An 'S'
// always restarts the frame, a stray CR or LF while idle is ignored and any
// other unexpected byte at the terminator drops the frame. Ticks advance a
// saturating watchdog; once it reaches cfg link timeout without a good frame
// a stop command (event 2, joystick 0x35) is issued and the watchdog
// restarts. The block takes one item per clock cycle while not stalled. An
// accepted item sits in the input register and goes through the parse logic
// into the result register. A result held by the sink stalls the input
// register, and once both registers are full the input stalls too. The
// timeout register is written through cfg_we / cfg_wdata; the user must write
// it only while the block is idle, as the block itself does not enforce this.
// depends on fcp_pkg, fcp_if and fcp_parser
`default_nettype none

module framed_command_parser_failsafe (
  input  wire logic        clk,
  input  wire logic        rst_n,
  fcp_in_if.sink           in_if,
  fcp_out_if.source        out_if,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_wdata
);

  // input register
  logic       in_v_r;
  logic       in_kind_r;
  logic [7:0] in_byte_r;

  // parser state and link timeout
  fcp_pkg::state_t st_r;
  fcp_pkg::state_t st_nxt;
  logic [15:0]     timeout_r;

  // result register
  logic             out_v_r;
  fcp_pkg::event_t  out_ev_r;
  logic [7:0]       out_joy_r;
  logic [7:0]       out_btn_r;
  fcp_pkg::result_t res;

  logic adv;   // result register free this cycle
  logic proc;  // item in the input register is processed this cycle

  assign adv   = !out_v_r || out_if.ready;
  assign proc  = in_v_r && adv;

  // input register refills whenever its item moves on
  assign in_if.ready = !in_v_r || adv;

  fcp_parser u_parser (
    .cur     (st_r),
    .kind    (in_kind_r),
    .rx_byte (in_byte_r),
    .timeout (timeout_r),
    .nxt     (st_nxt),
    .res     (res)
  );

  // input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_if.ready) begin
      in_v_r <= in_if.valid;
    end
    if (in_if.valid && in_if.ready) begin
      in_kind_r <= in_if.kind;
      in_byte_r <= in_if.rx_byte;
    end
  end

  // parser state, updated once per processed item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.phase <= fcp_pkg::PH_IDLE;
      st_r.joy   <= fcp_pkg::STOP_JOY;
      st_r.btn   <= fcp_pkg::BTN_RESET;
      st_r.chk   <= '0;
      st_r.wdog  <= '0;
    end else if (proc) begin
      st_r <= st_nxt;
    end
  end

  // link timeout register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= fcp_pkg::TIMEOUT_RESET;
    end else if (cfg_we) begin
      timeout_r <= cfg_wdata;
    end
  end

  // result stage: holds a result until the sink takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= proc && res.valid;
    end
    if (proc && res.valid) begin
      out_ev_r  <= res.event_res;
      out_joy_r <= res.joystick_code;
      out_btn_r <= res.button_code;
    end
  end

  assign out_if.valid         = out_v_r;
  assign out_if.event_res     = out_ev_r;
  assign out_if.joystick_code = out_joy_r;
  assign out_if.button_code   = out_btn_r;

endmodule

`default_nettype wire

FILE: rtl/fcp_parser.sv
// next-state and result logic for one item: frame parsing and link watchdog
// depends on fcp_pkg
`default_nettype none

module fcp_parser (
  input  fcp_pkg::state_t  cur,
  input  logic             kind,
  input  logic [7:0]       rx_byte,
  input  logic [15:0]      timeout,
  output fcp_pkg::state_t  nxt,
  output fcp_pkg::result_t res
);

  logic [15:0] wdog_inc;
  logic        is_term;
  logic [7:0]  calc;

  // saturating tick count
  assign wdog_inc = (cur.wdog != fcp_pkg::WDOG_MAX) ? cur.wdog + 16'd1 : cur.wdog;
  assign is_term  = (rx_byte == fcp_pkg::CR_BYTE) || (rx_byte == fcp_pkg::LF_BYTE);
  assign calc     = fcp_pkg::START_BYTE ^ cur.joy ^ cur.btn;

  always_comb begin
    nxt               = cur;
    res.valid         = 1'b0;
    res.event_res     = fcp_pkg::EV_DRIVE;
    res.joystick_code = cur.joy;
    res.button_code   = cur.btn;

    if (kind == fcp_pkg::KIND_TICK) begin
      nxt.wdog = wdog_inc;
      if (wdog_inc >= timeout) begin
        nxt.wdog          = '0;
        res.valid         = 1'b1;
        res.event_res     = fcp_pkg::EV_LOST;
        res.joystick_code = fcp_pkg::STOP_JOY;
      end
    end else if (rx_byte == fcp_pkg::START_BYTE) begin
      // start byte restarts the frame from anywhere
      nxt.phase = fcp_pkg::PH_JOY;
    end else begin
      unique case (cur.phase)
        fcp_pkg::PH_JOY: begin
          nxt.joy   = rx_byte;
          nxt.phase = fcp_pkg::PH_BTN;
        end
        fcp_pkg::PH_BTN: begin
          nxt.btn   = rx_byte;
          nxt.phase = fcp_pkg::PH_CHK;
        end
        fcp_pkg::PH_CHK: begin
          nxt.chk   = rx_byte;
          nxt.phase = fcp_pkg::PH_TERM;
        end
        fcp_pkg::PH_TERM: begin
          nxt.phase = fcp_pkg::PH_IDLE;
          if (is_term) begin
            res.valid = 1'b1;
            if (calc == cur.chk) begin
              nxt.wdog      = '0;
              res.event_res = fcp_pkg::EV_DRIVE;
            end else begin
              res.event_res = fcp_pkg::EV_MISMATCH;
            end
          end
        end
        default: begin
          // idle: stray terminators and other bytes leave it idle
          nxt.phase = fcp_pkg::PH_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: rtl/fcp_checker.sv
// port-level checks for the framed command parser, bound to the top level
// depends on fcp_pkg and the assertion macro header
`default_nettype none
`include "framed_command_parser_failsafe_macros.svh"

module fcp_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [1:0] out_event_res,
  input wire logic [7:0] out_joystick_code,
  input wire logic [7:0] out_button_code
);

  // a stalled result holds
  `FCP_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_event_res) && $stable(out_joystick_code) && $stable(out_button_code), "stalled result changed")

  // only the three event codes are ever shown
  `FCP_ASSERT_IMP(a_event_code, clk, rst_n, out_valid, out_event_res == fcp_pkg::EV_DRIVE || out_event_res == fcp_pkg::EV_MISMATCH || out_event_res == fcp_pkg::EV_LOST, "bad event code")

  // link lost always commands the stop direction
  `FCP_ASSERT_IMP(a_lost_stop, clk, rst_n, out_valid && out_event_res == fcp_pkg::EV_LOST, out_joystick_code == fcp_pkg::STOP_JOY, "link lost without stop code")

  // nothing comes out in the cycle after reset
  `FCP_ASSERT_IMP(a_reset_quiet, clk, rst_n, $past(!rst_n), !out_valid, "result right after reset")

endmodule

bind framed_command_parser_failsafe fcp_checker u_fcp_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_if.valid),
  .out_ready         (out_if.ready),
  .out_event_res     (out_if.event_res),
  .out_joystick_code (out_if.joystick_code),
  .out_button_code   (out_if.button_code)
);

`default_nettype wire
